@@ hw/rtl/lpds_pkg.sv @@
// ----------------------------------------------------------------------------
// lpds_pkg
// Shared widths, constants and types for the largest proper divisor block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpds_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int DIVISOR_W   = VALUE_WIDTH - 1;
  localparam int TRIAL_W     = VALUE_WIDTH / 2 + 1;
  localparam int SUM_W       = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DIVISOR_W + SUM_W + 7) / 8) * 8;

  localparam logic [TRIAL_W-1:0]   FIRST_TRIAL  = TRIAL_W'(2);
  localparam logic [TRIAL_W-1:0]   SECOND_TRIAL = TRIAL_W'(3);
  localparam logic [TRIAL_W-1:0]   ODD_STEP     = TRIAL_W'(2);
  localparam logic [DIVISOR_W-1:0] NO_DIVISOR   = DIVISOR_W'(1);
  localparam logic [SUM_W-1:0]     SUM_MAX      = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } lpds_state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/lpds_div.sv @@
// ----------------------------------------------------------------------------
// lpds_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpds_div import lpds_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [TRIAL_W-1:0]     divisor,
  output logic [VALUE_WIDTH-1:0]      quotient,
  output div_status_t                 status
);

  logic                   busy;
  logic                   done;
  logic [CNT_W-1:0]       cnt;
  logic [TRIAL_W-1:0]     rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic [TRIAL_W:0]       trial;
  logic                   fits;

  always_comb begin
    trial = {rem, quo[VALUE_WIDTH-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= TRIAL_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[TRIAL_W-1:0];
      end
      quo <= {quo[VALUE_WIDTH-2:0], fits};
    end
  end

  assign quotient        = quo;
  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

endmodule

`default_nettype wire

@@ hw/rtl/largest_proper_divisor_sum.sv @@
// ----------------------------------------------------------------------------
// largest_proper_divisor_sum
// Largest proper divisor by trial division, with a saturating group sum.
// ----------------------------------------------------------------------------
// Input channel s_*: one number per item in s_tdata, s_tlast closes a group.
// Output channel m_*: one result per item: divisor and running group sum in
// m_tdata, m_tlast copies the group flag of the item.
// Candidates 2, 3, 5, 7, ... are tried in turn on one bit-serial divider,
// one quotient bit per cycle. The search stops at the first zero remainder
// or once the candidate exceeds the quotient. An item that tries k
// candidates (1 when its smallest factor is 2, (f + 1) / 2 when it is an odd
// f) is emitted on m_tvalid after its k divider runs; a prime near 65535
// tries 129 candidates. One item is worked on at a time; s_tready is high
// only while idle, and the next item is taken after this one is emitted.
// The finished result sits in an output register, so the next item is taken
// while it waits; a stalled receiver holds the block at its next result.
// Synchronous reset clears the group sum and drops any pending item.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_proper_divisor_sum import lpds_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // value
  input  wire logic                   s_tlast,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // divisor, group_sum, zero pad
  output logic                        m_tlast
);

  lpds_state_t            state;
  lpds_state_t            state_next;
  logic [VALUE_WIDTH-1:0] value;
  logic                   last;
  logic [TRIAL_W-1:0]     trial;
  logic [TRIAL_W-1:0]     trial_next;
  logic [DIVISOR_W-1:0]   result;
  logic [SUM_W-1:0]       running_sum;
  logic [SUM_W:0]         sum_wide;
  logic [SUM_W-1:0]       sum_sat;
  logic [DIVISOR_W-1:0]   out_div;
  logic [SUM_W-1:0]       out_sum;
  logic                   out_last;
  logic                   out_valid;
  logic                   div_start;
  logic                   emit_load;
  logic                   search_over;
  logic [VALUE_WIDTH-1:0] quotient;
  div_status_t            status;

  function automatic logic search_over_bound(input logic [TRIAL_W-1:0] t,
                                             input logic [VALUE_WIDTH-1:0] q);
    search_over_bound = ({{(VALUE_WIDTH-TRIAL_W){1'b0}}, t} > q);
  endfunction

  lpds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (value),
    .divisor  (trial),
    .quotient (quotient),
    .status   (status)
  );

  always_comb begin
    search_over = ({{(VALUE_WIDTH-TRIAL_W){1'b0}}, trial} > quotient) || status.rem_zero;
    trial_next  = (trial == FIRST_TRIAL) ? SECOND_TRIAL : trial + ODD_STEP;
    sum_wide    = {1'b0, running_sum} + (SUM_W+1)'(result);
    sum_sat     = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = ST_WAIT;
      ST_WAIT: begin
        if (status.done) begin
          state_next = search_over ? ST_EMIT : ST_START;
        end
      end
      ST_EMIT: begin
        if (!out_valid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    emit_load = 1'b0;
    case (state)
      ST_IDLE:  s_tready  = 1'b1;
      ST_START: div_start = 1'b1;
      ST_WAIT:  ;
      ST_EMIT:  emit_load = !out_valid || m_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_load) begin
        out_valid   <= 1'b1;
        running_sum <= last ? '0 : sum_sat;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      value <= s_tdata[VALUE_WIDTH-1:0];
      last  <= s_tlast;
      trial <= FIRST_TRIAL;
    end else if (state == ST_WAIT && status.done && !search_over) begin
      trial <= trial_next;
    end
    if (state == ST_WAIT && status.done) begin
      result <= status.rem_zero && !search_over_bound(trial, quotient)
                ? quotient[DIVISOR_W-1:0] : NO_DIVISOR;
    end
    if (emit_load) begin
      out_div  <= result;
      out_sum  <= sum_sat;
      out_last <= last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'({out_sum, out_div});
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of largest_proper_divisor_sum. Numbers go in one item at
// a time; every item is predicted on acceptance (largest proper divisor and
// saturating group sum) and each result is checked in order against it.
// Covers edge values, group boundaries, back-pressure, random traffic with
// gaps on both sides, and a long group of the largest divisors.
// ----------------------------------------------------------------------------

module tb import lpds_pkg::*; ();

  localparam int CLK_PERIOD    = 20;
  localparam int GAP_PCT       = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 10000;
  localparam int TAIL_CYCLES   = 200;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int LONG_ITEMS    = 64;
  localparam int TOP_DIVISOR   = (1 << DIVISOR_W) - 1;

  typedef struct {
    logic [DIVISOR_W-1:0] divisor;
    logic [SUM_W-1:0]     group_sum;
    logic                 group_done;
  } divisor_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  divisor_result_t        pending_results[$];
  divisor_result_t        want;
  logic [SUM_W-1:0]       group_total = '0;
  logic [SUM_W:0]         wide_sum;
  logic                   gaps_on = 1'b1;
  int                     hold_requests = 0;
  int                     holds_served = 0;
  int                     hold_left = 0;
  int                     quiet_cycles = 0;
  int                     error_count = 0;

  largest_proper_divisor_sum u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [DIVISOR_W-1:0] largest_divisor_of(
    input logic [VALUE_WIDTH-1:0] value
  );
    int unsigned v;
    v = value;
    for (int unsigned f = 2; f * f <= v; f++) begin
      if (v % f == 0) return DIVISOR_W'(v / f);
    end
    return NO_DIVISOR;
  endfunction

  // check the oldest expectation first, then record the newly accepted item
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: divisor %0d group_sum %0d",
                 m_tdata[DIVISOR_W-1:0], m_tdata[DIVISOR_W +: SUM_W]);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[DIVISOR_W-1:0] !== want.divisor) begin
            $error("divisor: expected %0d, got %0d", want.divisor,
                   m_tdata[DIVISOR_W-1:0]);
            error_count++;
          end
          if (m_tdata[DIVISOR_W +: SUM_W] !== want.group_sum) begin
            $error("group_sum: expected %0d, got %0d", want.group_sum,
                   m_tdata[DIVISOR_W +: SUM_W]);
            error_count++;
          end
          if (m_tlast !== want.group_done) begin
            $error("group_done: expected %0b, got %0b", want.group_done, m_tlast);
            error_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want.divisor    = largest_divisor_of(s_tdata[VALUE_WIDTH-1:0]);
        wide_sum        = {1'b0, group_total} + (SUM_W+1)'(want.divisor);
        want.group_sum  = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
        want.group_done = s_tlast;
        pending_results.push_back(want);
        group_total = s_tlast ? '0 : want.group_sum;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 1'b0;
    end else if (gaps_on) begin
      m_tready = ($urandom_range(99) >= GAP_PCT);
    end else begin
      m_tready = 1'b1;
    end
  end

  task automatic send_item(input logic [VALUE_WIDTH-1:0] value, input logic last);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      s_tvalid = 1'b0;
      s_tdata  = IN_TDATA_W'($urandom);
      s_tlast  = 1'($urandom_range(1));
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = IN_TDATA_W'(value);
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(16'd4, 1'b1);
    send_item(16'd2, 1'b0);
    send_item(16'd3, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b1);
    send_item(16'd9, 1'b0);
    send_item(16'd25, 1'b0);
    send_item(16'd32768, 1'b0);
    send_item(16'(2 * TOP_DIVISOR), 1'b0);
    send_item(16'hFFFF, 1'b1);
    send_item(16'd65521, 1'b0);
    send_item(16'd63001, 1'b0);
    send_item(16'd65025, 1'b0);
    send_item(16'd65533, 1'b0);
    send_item(16'd49, 1'b0);
    send_item(16'd289, 1'b0);
    send_item(16'd6, 1'b0);
    send_item(16'd7, 1'b1);
    send_item(16'hFFFF, 1'b1);
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_requests++;
    for (int i = 0; i < 12; i++) begin
      send_item(16'(2 * $urandom_range(2, 500)), 1'($urandom_range(3) == 0));
    end
    drain_results();
    for (int i = 0; i < 8; i++) begin
      send_item(16'($urandom_range(2, 300)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random();
    logic [VALUE_WIDTH-1:0] value;
    int                     pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = !(i >= 700 && i < 1000);
      pick = $urandom_range(99);
      if (pick < 60) value = 16'($urandom_range(2, 1023));
      else if (pick < 70) value = 16'(2 * $urandom_range(1, TOP_DIVISOR));
      else value = 16'($urandom_range(0, 65535));
      send_item(value, 1'($urandom_range(7) == 0));
    end
    gaps_on = 1'b1;
  endtask

  // build one long group of the largest divisors, then show it restarts at zero
  task automatic test_long_group();
    send_item(16'd4, 1'b1);
    gaps_on = 1'b0;
    for (int i = 0; i < LONG_ITEMS; i++) send_item(16'(2 * TOP_DIVISOR), 1'b0);
    send_item(16'd8, 1'b1);
    send_item(16'd15, 1'b1);
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    test_long_group();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/lpds_pkg.sv
hw/rtl/lpds_div.sv
hw/rtl/largest_proper_divisor_sum.sv
tb/tb.sv
